FILE: design/rfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  // Largest payload length plus one: a frame carries at most MaxPayload - 1 bytes.
  localparam logic [16:0] MaxPayload = 17'd256;

  localparam logic [7:0] StartByte = 8'hFE;
  localparam logic [7:0] EndByte   = 8'hFD;

  // Index of the last header byte (the low byte of the length).
  localparam logic [2:0] HeaderLastIdx = 3'd5;

  localparam int unsigned OutDataWidth = 56;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_TERM    = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_START    = 2'd0,
    ERR_TOO_LONG     = 2'd1,
    ERR_BAD_TERM     = 2'd2,
    ERR_SEQ_MISMATCH = 2'd3
  } error_e;

endpackage

`default_nettype wire

FILE: design/response_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Response frame deframer. Received serial bytes enter on the s_axis side, one
// request per byte, and the block takes one byte per cycle when ready. Each frame
// is a six-byte header (start 0xFE, command type, command, sequence, length high,
// length low), then the payload, then a terminator 0xFD. When the length is below
// the maximum payload, each payload byte appears on m_axis in the cycle after it
// arrives with tuser = 0, and the final one carries tlast. At the end of a frame a
// single request reports either an accepted frame (tuser = 1) or an error
// (tuser = 2) with its code, together with the header fields. If a frame ends in
// error, discard any payload already delivered for it. A frame whose start byte is
// wrong ends right after its header. A frame that is too long is read to its
// terminator with no payload delivered. The only storage between the two sides is
// the result register, so s_axis_tready falls only while a result is held there
// and m_axis_tready is low. The expected sequence number is written through the
// cfg port, which is always ready. Write it only while no frame is in progress.
module response_frame_deframer (
  input  var logic        clk_i,
  input  var logic        rst_ni,

  input  var logic        s_axis_tvalid,
  output var logic        s_axis_tready,
  input  var logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

  output var logic        m_axis_tvalid,
  input  var logic        m_axis_tready,
  // [7:0] data_byte, [15:8] frame_type, [23:16] frame_command,
  // [31:24] frame_sequence, [47:32] frame_length, [49:48] error_code, rest zero
  output var logic [55:0] m_axis_tdata,
  output var logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output var logic        m_axis_tlast,   // last_payload

  input  var logic        cfg_valid_i,
  output var logic        cfg_ready_o,
  input  var logic [7:0]  cfg_data_i      // expected_sequence
);

  // Frame state.
  rfd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  header_index_q, header_index_d;
  logic [15:0] bytes_remaining_q, bytes_remaining_d;
  logic [7:0]  held_start_q, held_start_d;
  logic [7:0]  held_type_q, held_type_d;
  logic [7:0]  held_command_q, held_command_d;
  logic [7:0]  held_sequence_q, held_sequence_d;
  logic [15:0] held_length_q, held_length_d;
  logic [7:0]  expected_seq_q;

  // Result register.
  logic                              out_valid_q, out_valid_d;
  rfd_pkg::kind_e                    out_kind_q, out_kind_d;
  logic [rfd_pkg::OutDataWidth-1:0]  out_data_q, out_data_d;
  logic                              out_last_q, out_last_d;

  logic        in_fire;
  logic        emit;
  logic        length_ok;
  logic [15:0] header_length;
  rfd_pkg::error_e err_code;

  // A byte can enter whenever the result register is empty or is being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign length_ok = {1'b0, held_length_q} < rfd_pkg::MaxPayload;

  // The length as it stands once the low byte is taken in.
  assign header_length = {held_length_q[15:8], s_axis_tdata};

  always_comb begin
    phase_d           = phase_q;
    header_index_d    = header_index_q;
    bytes_remaining_d = bytes_remaining_q;
    held_start_d      = held_start_q;
    held_type_d       = held_type_q;
    held_command_d    = held_command_q;
    held_sequence_d   = held_sequence_q;
    held_length_d     = held_length_q;
    emit              = 1'b0;
    out_kind_d        = rfd_pkg::KIND_PAYLOAD;
    out_last_d        = 1'b0;
    err_code          = rfd_pkg::ERR_BAD_START;
    out_data_d        = '0;

    case (phase_q)
      rfd_pkg::PH_PAYLOAD: begin
        if (length_ok) begin
          emit             = 1'b1;
          out_data_d[7:0]  = s_axis_tdata;
          out_last_d       = (bytes_remaining_q == 16'd1);
        end
        bytes_remaining_d = bytes_remaining_q - 16'd1;
        if (bytes_remaining_q == 16'd1) begin
          phase_d = rfd_pkg::PH_TERM;
        end
      end
      rfd_pkg::PH_TERM: begin
        phase_d        = rfd_pkg::PH_HEADER;
        header_index_d = '0;
        emit           = 1'b1;
        // Checks in priority order: length, terminator value, sequence.
        if (!length_ok) begin
          out_kind_d = rfd_pkg::KIND_ERROR;
          err_code   = rfd_pkg::ERR_TOO_LONG;
        end else if (s_axis_tdata != rfd_pkg::EndByte) begin
          out_kind_d = rfd_pkg::KIND_ERROR;
          err_code   = rfd_pkg::ERR_BAD_TERM;
        end else if (held_sequence_q != expected_seq_q) begin
          out_kind_d = rfd_pkg::KIND_ERROR;
          err_code   = rfd_pkg::ERR_SEQ_MISMATCH;
        end else begin
          out_kind_d = rfd_pkg::KIND_ACCEPTED;
        end
        out_data_d[15:8]  = held_type_q;
        out_data_d[23:16] = held_command_q;
        out_data_d[31:24] = held_sequence_q;
        out_data_d[47:32] = held_length_q;
        out_data_d[49:48] = err_code;
      end
      default: begin
        phase_d = rfd_pkg::PH_HEADER;
        case (header_index_q)
          3'd0:    held_start_d    = s_axis_tdata;
          3'd1:    held_type_d     = s_axis_tdata;
          3'd2:    held_command_d  = s_axis_tdata;
          3'd3:    held_sequence_d = s_axis_tdata;
          3'd4:    held_length_d   = {s_axis_tdata, held_length_q[7:0]};
          default: held_length_d   = header_length;
        endcase
        if (header_index_q < rfd_pkg::HeaderLastIdx) begin
          header_index_d = header_index_q + 3'd1;
        end else begin
          header_index_d = '0;
          if (held_start_q != rfd_pkg::StartByte) begin
            // Bad start: the frame ends here, nothing more is consumed for it.
            emit              = 1'b1;
            out_kind_d        = rfd_pkg::KIND_ERROR;
            out_data_d[15:8]  = held_type_q;
            out_data_d[23:16] = held_command_q;
            out_data_d[31:24] = held_sequence_q;
            out_data_d[47:32] = header_length;
            out_data_d[49:48] = rfd_pkg::ERR_BAD_START;
          end else begin
            bytes_remaining_d = header_length;
            phase_d = (header_length == 16'd0) ? rfd_pkg::PH_TERM : rfd_pkg::PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  // The result register fills on an accepted byte that yields a result and
  // empties when the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= rfd_pkg::PH_HEADER;
      header_index_q    <= '0;
      bytes_remaining_q <= '0;
      held_start_q      <= '0;
      held_type_q       <= '0;
      held_command_q    <= '0;
      held_sequence_q   <= '0;
      held_length_q     <= '0;
      expected_seq_q    <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q           <= phase_d;
        header_index_q    <= header_index_d;
        bytes_remaining_q <= bytes_remaining_d;
        held_start_q      <= held_start_d;
        held_type_q       <= held_type_d;
        held_command_q    <= held_command_d;
        held_sequence_q   <= held_sequence_d;
        held_length_q     <= held_length_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        expected_seq_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_kind_q <= out_kind_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // A terminator byte always produces a frame-end request in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == rfd_pkg::PH_TERM) |=>
      (m_axis_tvalid && m_axis_tuser != rfd_pkg::KIND_PAYLOAD))
    else $error("terminator did not produce a frame-end request");

  // While in the payload phase there is always at least one byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rfd_pkg::PH_PAYLOAD) |-> (bytes_remaining_q != 16'd0))
    else $error("payload phase with no bytes remaining");

  // The header index never runs past the last header byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_index_q <= rfd_pkg::HeaderLastIdx)
    else $error("header index out of range");

  // Only payload requests carry tlast.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == rfd_pkg::KIND_PAYLOAD))
    else $error("tlast on a frame-end request");

  // Leaving the terminator phase always returns to header collection at index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == rfd_pkg::PH_TERM) |=>
      (phase_q == rfd_pkg::PH_HEADER && header_index_q == 3'd0))
    else $error("frame end did not restart header collection");

endmodule

`default_nettype wire

FILE: tb/response_frame_deframer_tb.sv
`timescale 1ns / 1ps

module response_frame_deframer_tb;
  import rfd_pkg::*;

  // One result as the deframer should present it on m_axis.
  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic        tlast;
    logic [7:0]  ftype;
    logic [7:0]  fcmd;
    logic [7:0]  fseq;
    logic [15:0] flen;
    error_e      code;
  } deframe_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;

  response_frame_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Deframer state as predicted from the bytes accepted so far.
  phase_e      link_phase   = PH_HEADER;
  logic [2:0]  hdr_pos      = 3'd0;
  logic [15:0] payload_left = 16'd0;
  logic [7:0]  hdr_start    = 8'h00;
  logic [7:0]  hdr_type     = 8'h00;
  logic [7:0]  hdr_cmd      = 8'h00;
  logic [7:0]  hdr_seq      = 8'h00;
  logic [15:0] hdr_len      = 16'd0;
  logic [7:0]  seq_expected = 8'h00;

  deframe_result_t expected_results[$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  int mismatch_count = 0;
  int bytes_sent = 0;
  int payload_seen = 0;
  int accepted_seen = 0;
  int errors_seen = 0;
  int config_writes = 0;

  function automatic deframe_result_t frame_end(input kind_e k, input error_e e);
    deframe_result_t r;
    r.kind  = k;
    r.data  = 8'h00;
    r.tlast = 1'b0;
    r.ftype = hdr_type;
    r.fcmd  = hdr_cmd;
    r.fseq  = hdr_seq;
    r.flen  = hdr_len;
    r.code  = e;
    return r;
  endfunction

  // Advances the predicted state by one received byte and queues any result.
  task automatic deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    case (link_phase)
      PH_PAYLOAD: begin
        // Oversized frames are consumed silently up to the terminator.
        if ({1'b0, hdr_len} < MaxPayload) begin
          r = frame_end(KIND_PAYLOAD, ERR_BAD_START);
          r.ftype = 8'h00;
          r.fcmd  = 8'h00;
          r.fseq  = 8'h00;
          r.flen  = 16'd0;
          r.data  = b;
          r.tlast = (payload_left == 16'd1);
          expected_results.push_back(r);
        end
        payload_left = payload_left - 16'd1;
        if (payload_left == 16'd0) link_phase = PH_TERM;
      end
      PH_TERM: begin
        link_phase = PH_HEADER;
        hdr_pos    = 3'd0;
        // Length is judged first, then the terminator, then the sequence.
        if ({1'b0, hdr_len} >= MaxPayload)
          expected_results.push_back(frame_end(KIND_ERROR, ERR_TOO_LONG));
        else if (b != EndByte)
          expected_results.push_back(frame_end(KIND_ERROR, ERR_BAD_TERM));
        else if (hdr_seq != seq_expected)
          expected_results.push_back(frame_end(KIND_ERROR, ERR_SEQ_MISMATCH));
        else
          expected_results.push_back(frame_end(KIND_ACCEPTED, ERR_BAD_START));
      end
      default: begin
        case (hdr_pos)
          3'd0:    hdr_start = b;
          3'd1:    hdr_type = b;
          3'd2:    hdr_cmd = b;
          3'd3:    hdr_seq = b;
          3'd4:    hdr_len[15:8] = b;
          default: hdr_len[7:0] = b;
        endcase
        if (hdr_pos < HeaderLastIdx) begin
          hdr_pos = hdr_pos + 3'd1;
        end else begin
          hdr_pos = 3'd0;
          if (hdr_start != StartByte) begin
            expected_results.push_back(frame_end(KIND_ERROR, ERR_BAD_START));
          end else begin
            payload_left = hdr_len;
            link_phase   = (hdr_len == 16'd0) ? PH_TERM : PH_PAYLOAD;
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    deframe_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, tuser", 32'(m_axis_tuser), 32'h0);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 32'(m_axis_tuser), 32'(want.kind));
        check_field("data_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
        check_field("last_payload", 32'(m_axis_tlast), 32'(want.tlast));
        check_field("frame_type", 32'(m_axis_tdata[15:8]), 32'(want.ftype));
        check_field("frame_command", 32'(m_axis_tdata[23:16]), 32'(want.fcmd));
        check_field("frame_sequence", 32'(m_axis_tdata[31:24]), 32'(want.fseq));
        check_field("frame_length", 32'(m_axis_tdata[47:32]), 32'(want.flen));
        check_field("error_code", 32'(m_axis_tdata[49:48]), 32'(want.code));
        check_field("tdata padding", 32'(m_axis_tdata[55:50]), 32'h0);
        case (want.kind)
          KIND_PAYLOAD:  payload_seen++;
          KIND_ACCEPTED: accepted_seen++;
          default:       errors_seen++;
        endcase
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // The sender pauses until every predicted result has been delivered.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_expected_sequence(input logic [7:0] value);
    wait_for_drain();
    // Header bytes give no result, so let the block settle before the write.
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seq_expected = value;
    config_writes++;
  endtask

  // A header, random payload when the start byte is right, then the terminator.
  task automatic send_frame(input logic [7:0] start, input logic [7:0] ftype,
                            input logic [7:0] fcmd, input logic [7:0] fseq,
                            input logic [15:0] flen, input logic [7:0] term);
    send_byte(start);
    send_byte(ftype);
    send_byte(fcmd);
    send_byte(fseq);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    if (start == StartByte) begin
      repeat (flen) send_byte(8'($urandom));
      send_byte(term);
    end
  endtask

  // Random line noise, kept from opening a frame with a huge length.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (link_phase == PH_HEADER && hdr_pos == 3'd4 && hdr_start == StartByte)
      b = 8'h00;
    return b;
  endfunction

  task automatic send_noise_burst();
    repeat ($urandom_range(1, 10)) send_byte(noise_byte());
    // Carry on until the deframer is back at a frame boundary.
    while (!(link_phase == PH_HEADER && hdr_pos == 3'd0)) send_byte(noise_byte());
  endtask

  task automatic send_random_frame();
    int pick;
    logic [7:0] start;
    logic [7:0] fseq;
    logic [7:0] term;
    logic [15:0] flen;
    pick  = $urandom_range(99);
    start = StartByte;
    fseq  = seq_expected;
    term  = EndByte;
    flen  = ($urandom_range(9) == 0) ? 16'($urandom_range(60)) : 16'($urandom_range(12));
    if (pick < 14) begin
      send_noise_burst();
    end else begin
      if (pick < 22) begin
        start = 8'($urandom);
        if (start == StartByte) start = 8'h00;
      end else if (pick < 29) begin
        // A bad terminator and a wrong sequence together: the terminator wins.
        fseq = seq_expected + 8'($urandom_range(1, 255));
        term = 8'($urandom);
        if (term == EndByte) term = 8'h00;
      end else if (pick < 37) begin
        term = 8'($urandom);
        if (term == EndByte) term = 8'h00;
      end else if (pick < 45) begin
        fseq = seq_expected + 8'($urandom_range(1, 255));
      end
      send_frame(start, 8'($urandom), 8'($urandom), fseq, flen, term);
    end
  endtask

  // Good frames, a zero-length frame, a bad start and a bad terminator.
  task automatic test_frame_basics();
    set_idling(0, 0);
    send_frame(StartByte, 8'h00, 8'h00, 8'h00, 16'd0, EndByte);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_frame(StartByte, 8'h5A, 8'hA5, 8'h00, 16'd1, EndByte);
    send_frame(StartByte, 8'h01, 8'h80, 8'h00, 16'd0, 8'h00);
  endtask

  // The sequence register at both extremes, mismatches and check order.
  task automatic test_sequence_register();
    write_expected_sequence(8'hFF);
    send_frame(StartByte, 8'h10, 8'h20, 8'hFF, 16'd0, EndByte);
    send_frame(StartByte, 8'h10, 8'h21, 8'hFE, 16'd3, EndByte);
    send_frame(StartByte, 8'h10, 8'h22, 8'h00, 16'd2, 8'hFC);
    write_expected_sequence(8'h00);
    send_frame(StartByte, 8'h11, 8'h23, 8'h00, 16'd2, EndByte);
    write_expected_sequence(8'h5A);
    send_frame(StartByte, 8'h12, 8'h24, 8'h5A, 16'd1, EndByte);
    send_frame(StartByte, 8'h12, 8'h25, 8'h00, 16'd0, EndByte);
  endtask

  // The payload limit: largest valid length and the limit itself.
  task automatic test_length_limit();
    set_idling(0, 0);
    send_frame(StartByte, 8'h21, 8'h31, seq_expected, 16'd255, EndByte);
    // Too long wins over both a bad terminator and a wrong sequence.
    send_frame(StartByte, 8'h22, 8'h32, ~seq_expected, 16'd256, 8'h00);
  endtask

  // A long receiver hold-off fills the result register and stalls the input.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    wait_for_drain();
    hold_request = 200;
    send_frame(StartByte, 8'h40, 8'h41, seq_expected, 16'd24, EndByte);
    send_frame(StartByte, 8'h42, 8'h43, seq_expected, 16'd5, EndByte);
    wait_for_drain();
    send_frame(StartByte, 8'h44, 8'h45, seq_expected, 16'd4, EndByte);
  endtask

  task automatic test_random_traffic();
    int phase_no;
    int phase_start;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0:       set_idling(0, 0);
        1:       set_idling(70, 0);
        2:       set_idling(0, 70);
        default: set_idling(10, 10);
      endcase
      write_expected_sequence(8'($urandom));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 20) begin
        send_random_frame();
        if ($urandom_range(29) == 0) wait_for_drain();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_basics();
    test_sequence_register();
    test_length_limit();
    test_output_backpressure();
    test_random_traffic();

    wait_for_drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d payload, %0d accepted and %0d error results.",
             bytes_sent, payload_seen, accepted_seen, errors_seen);
    $display("Expected sequence written %0d times; four idling mixes and a long hold-off.",
             config_writes);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("response_frame_deframer verification clean");
    end else begin
      $display("response_frame_deframer verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results still outstanding.", expected_results.size());
    $display("response_frame_deframer verification failed");
    $finish;
  end

endmodule

FILE: response_frame_deframer.f
design/rfd_pkg.sv
design/response_frame_deframer.sv
tb/response_frame_deframer_tb.sv
